// File: rtl/core/alfl_pkg.sv
package alfl_pkg;

   // pool geometry
   localparam int SLOT_COUNT = 128;
   localparam int SLOT_WIDTH = $clog2(SLOT_COUNT);
   localparam int LINK_WIDTH = $clog2(SLOT_COUNT + 1);

   typedef logic [SLOT_WIDTH-1:0] slot_type;
   typedef logic [LINK_WIDTH-1:0] link_type;
   typedef logic signed [31:0]    value_type;

   // null link sits one past the last slot
   localparam link_type NIL = link_type'(SLOT_COUNT);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_FIND   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_WALK,
      ST_RELEASE
   } state_type;

   typedef struct packed {
      logic [1:0] opcode;
      value_type  value;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [6:0] slot;
      logic [7:0] entries;
   } rsp_type;

   // write port of the link memory
   typedef struct packed {
      logic     en;
      slot_type addr;
      link_type data;
   } link_wr_type;

   // write port of the value memory
   typedef struct packed {
      logic      en;
      slot_type  addr;
      value_type data;
   } value_wr_type;

   // any link past the pool counts as null
   function automatic link_type clamp_link(link_type n);
      return (n >= NIL) ? NIL : n;
   endfunction

endpackage

// File: rtl/core/alfl_value_ram.sv
module alfl_value_ram (
   input  logic                    clock,
   input  alfl_pkg::slot_type      rd_addr,
   output alfl_pkg::value_type     rd_data,
   input  alfl_pkg::value_wr_type  wr
);

   alfl_pkg::value_type mem [alfl_pkg::SLOT_COUNT];
   alfl_pkg::value_type rd_data_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/alfl_link_ram.sv
module alfl_link_ram (
   input  logic                   clock,
   input  logic                   reset,
   input  alfl_pkg::slot_type     rd_addr,
   output alfl_pkg::link_type     rd_data,
   input  alfl_pkg::link_wr_type  wr
);

   alfl_pkg::link_type mem [alfl_pkg::SLOT_COUNT];
   logic [alfl_pkg::SLOT_COUNT-1:0] valid_ff;
   alfl_pkg::link_type rd_data_ff;
   alfl_pkg::slot_type rd_addr_ff;
   logic               rd_valid_ff;

   // memory array and registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   // per-entry written flags, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // unwritten entry reads as its reset chain link, the last one as null
   assign rd_data = rd_valid_ff ? rd_data_ff
                                : alfl_pkg::link_type'(rd_addr_ff) + alfl_pkg::link_type'(1);

endmodule

// File: rtl/core/array_linked_list_free_list.sv
// Pool of alfl_pkg::SLOT_COUNT slots holding one singly linked list of signed values, with the
// free slots threaded through the same links. A transaction is taken when start is high and
// busy is low; exactly one result follows as a one-cycle rsp_valid strobe, and the receiver
// cannot stall it, so it must take the result in that cycle. Values and links live in two
// memories with registered reads. Insert reads the link of the first free slot, then stores
// the value and links the slot in at the head. Find and delete walk the list one slot per
// cycle; delete then passes a release state to relink. A walk with no match ends at the null
// link or after SLOT_COUNT slots. An empty list, a full pool or an unused opcode answers at
// once from idle. busy stays high until the result strobe has been given.
module array_linked_list_free_list (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  alfl_pkg::req_type req_data,
   output logic              rsp_valid,
   output alfl_pkg::rsp_type rsp_data
);

   alfl_pkg::state_type state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   alfl_pkg::value_type value_ff, value_in;
   alfl_pkg::link_type  cur_ff, cur_in;
   alfl_pkg::link_type  prev_ff, prev_in;
   alfl_pkg::link_type  steps_ff, steps_in;
   alfl_pkg::link_type  list_head_ff, list_head_in;
   alfl_pkg::link_type  free_head_ff, free_head_in;
   alfl_pkg::link_type  used_ff, used_in;
   logic                rsp_valid_ff, rsp_valid_in;
   alfl_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   alfl_pkg::link_type     rd_addr;
   alfl_pkg::link_type     link_rdata;
   alfl_pkg::value_type    value_rdata;
   alfl_pkg::link_wr_type  link_wr;
   alfl_pkg::value_wr_type value_wr;
   alfl_pkg::link_type     next_slot;

   alfl_value_ram u_value_ram (
      .clock   (clock),
      .rd_addr (rd_addr[alfl_pkg::SLOT_WIDTH-1:0]),
      .rd_data (value_rdata),
      .wr      (value_wr)
   );

   alfl_link_ram u_link_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr[alfl_pkg::SLOT_WIDTH-1:0]),
      .rd_data (link_rdata),
      .wr      (link_wr)
   );

   assign next_slot = alfl_pkg::clamp_link(link_rdata);

   // control and list state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= alfl_pkg::ST_IDLE;
         list_head_ff <= alfl_pkg::NIL;
         free_head_ff <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // transaction payload and walk pointers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      value_ff    <= value_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      steps_ff    <= steps_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sequencer: next state, memory accesses and result
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      steps_in     = steps_ff;
      list_head_in = list_head_ff;
      free_head_in = free_head_ff;
      used_in      = used_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = cur_ff;
      link_wr      = '0;
      value_wr     = '0;

      unique case (state_ff)
         alfl_pkg::ST_IDLE: begin
            if (start && !busy) begin
               op_in    = req_data.opcode;
               value_in = req_data.value;
               rsp_data_in.status  = alfl_pkg::STATUS_NOT_FOUND;
               rsp_data_in.slot    = '0;
               rsp_data_in.entries = 8'(used_ff);
               unique case (req_data.opcode) inside
                  alfl_pkg::OP_INSERT: begin
                     if (used_ff >= alfl_pkg::NIL || free_head_ff == alfl_pkg::NIL) begin
                        rsp_data_in.status = alfl_pkg::STATUS_FULL;
                        rsp_valid_in       = 1'b1;
                     end else begin
                        // fetch the link of the first free slot
                        rd_addr  = free_head_ff;
                        cur_in   = free_head_ff;
                        state_in = alfl_pkg::ST_INSERT;
                     end
                  end
                  alfl_pkg::OP_DELETE, alfl_pkg::OP_FIND: begin
                     if (list_head_ff == alfl_pkg::NIL) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        rd_addr  = list_head_ff;
                        cur_in   = list_head_ff;
                        prev_in  = alfl_pkg::NIL;
                        steps_in = alfl_pkg::link_type'(1);
                        state_in = alfl_pkg::ST_WALK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         alfl_pkg::ST_INSERT: begin
            // store value, link slot in at the list head
            value_wr.en   = 1'b1;
            value_wr.addr = cur_ff[alfl_pkg::SLOT_WIDTH-1:0];
            value_wr.data = value_ff;
            link_wr.en    = 1'b1;
            link_wr.addr  = cur_ff[alfl_pkg::SLOT_WIDTH-1:0];
            link_wr.data  = list_head_ff;
            list_head_in  = cur_ff;
            free_head_in  = next_slot;
            used_in       = used_ff + alfl_pkg::link_type'(1);
            rsp_data_in.status  = alfl_pkg::STATUS_DONE;
            rsp_data_in.slot    = 7'(cur_ff);
            rsp_data_in.entries = 8'(used_in);
            rsp_valid_in  = 1'b1;
            state_in      = alfl_pkg::ST_IDLE;
         end

         alfl_pkg::ST_WALK: begin
            if (value_rdata == value_ff) begin
               if (op_ff == alfl_pkg::OP_FIND) begin
                  rsp_data_in.status = alfl_pkg::STATUS_DONE;
                  rsp_data_in.slot   = 7'(cur_ff);
                  rsp_valid_in       = 1'b1;
                  state_in           = alfl_pkg::ST_IDLE;
               end else begin
                  // unlink the matching slot from its predecessor
                  if (prev_ff == alfl_pkg::NIL) begin
                     list_head_in = next_slot;
                  end else begin
                     link_wr.en   = 1'b1;
                     link_wr.addr = prev_ff[alfl_pkg::SLOT_WIDTH-1:0];
                     link_wr.data = next_slot;
                  end
                  state_in = alfl_pkg::ST_RELEASE;
               end
            end else if (next_slot == alfl_pkg::NIL || steps_ff >= alfl_pkg::NIL) begin
               rsp_valid_in = 1'b1;
               state_in     = alfl_pkg::ST_IDLE;
            end else begin
               // follow the link, one slot per cycle
               rd_addr  = next_slot;
               prev_in  = cur_ff;
               cur_in   = next_slot;
               steps_in = steps_ff + alfl_pkg::link_type'(1);
            end
         end

         alfl_pkg::ST_RELEASE: begin
            // push the freed slot onto the free list
            link_wr.en   = 1'b1;
            link_wr.addr = cur_ff[alfl_pkg::SLOT_WIDTH-1:0];
            link_wr.data = free_head_ff;
            free_head_in = cur_ff;
            if (used_ff != '0) begin
               used_in = used_ff - alfl_pkg::link_type'(1);
            end
            rsp_data_in.status  = alfl_pkg::STATUS_DONE;
            rsp_data_in.slot    = 7'(cur_ff);
            rsp_data_in.entries = 8'(used_in);
            rsp_valid_in = 1'b1;
            state_in     = alfl_pkg::ST_IDLE;
         end

         default: begin
            state_in = alfl_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != alfl_pkg::ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
